@@ hw/rtl/ffvd_pkg.sv @@
// ----------------------------------------------------------------------------
// ffvd_pkg
// Shared types and codes for the face fan vertex dedup block.
// ----------------------------------------------------------------------------
package ffvd_pkg;

  localparam int OUT_IDX_BITS = 10;
  localparam int STATUS_BITS  = 2;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOOKUP = 2'd1,
    OP_ERROR  = 2'd2
  } op_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NEG  = 2'd2
  } status_t;

endpackage

@@ hw/rtl/ffvd_ram.sv @@
// ----------------------------------------------------------------------------
// ffvd_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module ffvd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ hw/rtl/ffvd_queue.sv @@
// ----------------------------------------------------------------------------
// ffvd_queue
// Four-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module ffvd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  logic [WIDTH-1:0] entries [4];
  logic [1:0]       wr_ptr;
  logic [1:0]       rd_ptr;
  logic [2:0]       fill;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (fill != 3'd4);
  assign pop_valid  = (fill != 3'd0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 2'd1;
      if (do_pop)  rd_ptr <= rd_ptr + 2'd1;
      if (do_push && !do_pop) begin
        fill <= fill + 3'd1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 3'd1;
      end
    end
  end

endmodule

@@ hw/rtl/ffvd_front.sv @@
// ----------------------------------------------------------------------------
// ffvd_front
// Resolve corner indices, track the face fan and issue clear, lookup and error commands.
// ----------------------------------------------------------------------------
module ffvd_front #(
  parameter int IB = 24
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [IB-1:0]       pos_index,
  input  logic [IB-1:0]       uv_index,
  input  logic [IB-1:0]       normal_index,
  input  logic [IB-2:0]       pos_count,
  input  logic [IB-2:0]       uv_count,
  input  logic [IB-2:0]       normal_count,
  input  logic                face_start,
  input  logic                mesh_start,
  output logic                cmd_valid,
  input  logic                cmd_ready,
  output ffvd_pkg::op_t       cmd_op,
  output logic [3*(IB-1)-1:0] cmd_key,
  output logic                cmd_last
);

  localparam int KW = IB - 1;

  typedef enum logic [2:0] {S_IDLE, S_CLR, S_FIRST, S_PREV, S_CUR} state_t;

  state_t             state;
  logic [3*KW-1:0]    cur_key;
  logic [3*KW-1:0]    first_key;
  logic [3*KW-1:0]    prev_key;
  logic [1:0]         cif;
  logic               cur_err;
  logic               do_fan;
  logic               has_cur;

  logic [KW:0]        rp;
  logic [KW:0]        rt;
  logic [KW:0]        rn;
  logic [1:0]         cif_eff;
  logic               any_neg;
  logic               accept;

  function automatic logic [KW:0] resolve(input logic [IB-1:0] raw,
                                          input logic [KW-1:0] cnt);
    logic [IB:0] sum;
    sum = {raw[IB-1], raw} + {2'b00, cnt} + {{IB{1'b0}}, 1'b1};
    if (!raw[IB-1]) begin
      return {1'b0, raw[KW-1:0]};
    end
    return {sum[IB], sum[KW-1:0]};
  endfunction

  assign rp       = resolve(pos_index, pos_count);
  assign rt       = resolve(uv_index, uv_count);
  assign rn       = resolve(normal_index, normal_count);
  assign any_neg  = rp[KW] || rt[KW] || rn[KW];
  assign cif_eff  = (face_start || mesh_start) ? 2'd0 : cif;
  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    cmd_valid = 1'b0;
    cmd_op    = ffvd_pkg::OP_LOOKUP;
    cmd_key   = cur_key;
    cmd_last  = 1'b0;
    unique case (state)
      S_IDLE: begin
        cmd_valid = 1'b0;
      end
      S_CLR: begin
        cmd_valid = 1'b1;
        cmd_op    = ffvd_pkg::OP_CLEAR;
      end
      S_FIRST: begin
        cmd_valid = 1'b1;
        cmd_key   = first_key;
      end
      S_PREV: begin
        cmd_valid = 1'b1;
        cmd_key   = prev_key;
      end
      S_CUR: begin
        cmd_valid = 1'b1;
        cmd_last  = 1'b1;
        if (cur_err) begin
          cmd_op  = ffvd_pkg::OP_ERROR;
          cmd_key = '0;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cif       <= '0;
      first_key <= '0;
      prev_key  <= '0;
      cur_key   <= '0;
      cur_err   <= 1'b0;
      do_fan    <= 1'b0;
      has_cur   <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            cif     <= cif_eff;
            cur_key <= {rn[KW-1:0], rt[KW-1:0], rp[KW-1:0]};
            cur_err <= any_neg && (rp != '0);
            has_cur <= (rp != '0);
            do_fan  <= (rp != '0) && !any_neg && (cif_eff == 2'd3);
            if (mesh_start) begin
              state <= S_CLR;
            end else if (rp != '0) begin
              state <= (!any_neg && cif_eff == 2'd3) ? S_FIRST : S_CUR;
            end
          end
        end
        S_CLR: begin
          if (cmd_ready) begin
            priority if (do_fan) state <= S_FIRST;
            else if (has_cur)    state <= S_CUR;
            else                 state <= S_IDLE;
          end
        end
        S_FIRST: begin
          if (cmd_ready) state <= S_PREV;
        end
        S_PREV: begin
          if (cmd_ready) state <= S_CUR;
        end
        S_CUR: begin
          if (cmd_ready) begin
            state <= S_IDLE;
            if (!cur_err) begin
              if (cif == 2'd0) first_key <= cur_key;
              prev_key <= cur_key;
              if (cif != 2'd3) cif <= cif + 2'd1;
            end
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/ffvd_back.sv @@
// ----------------------------------------------------------------------------
// ffvd_back
// Scan the vertex key table, insert new keys and hold the result register.
// ----------------------------------------------------------------------------
module ffvd_back #(
  parameter int IB    = 24,
  parameter int DEPTH = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  output logic                cmd_ready,
  input  ffvd_pkg::op_t       cmd_op,
  input  logic [3*(IB-1)-1:0] cmd_key,
  input  logic                cmd_last,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [ffvd_pkg::OUT_IDX_BITS-1:0] out_vidx,
  output logic                out_new,
  output logic [3*(IB-1)-1:0] out_key,
  output ffvd_pkg::status_t   out_status,
  output logic                out_last
);

  localparam int KW = IB - 1;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 1;

  typedef enum logic [2:0] {S_IDLE, S_RD, S_CMP, S_MISS, S_EMIT} state_t;

  state_t            state;
  logic [CW-1:0]     count;
  logic [AW-1:0]     idx;
  logic [3*KW-1:0]   key;
  logic              last_q;
  logic [AW-1:0]     res_vidx;
  logic              res_new;
  ffvd_pkg::status_t res_status;
  logic              ram_we;
  logic [3*KW-1:0]   ram_rdata;
  logic [CW-1:0]     idx_inc;
  logic [AW+ffvd_pkg::OUT_IDX_BITS-1:0] vidx_wide;

  assign cmd_ready = (state == S_IDLE);
  assign ram_we    = (state == S_MISS) && (count < CW'(DEPTH));
  assign idx_inc   = {1'b0, idx} + {{AW{1'b0}}, 1'b1};
  assign vidx_wide = {{ffvd_pkg::OUT_IDX_BITS{1'b0}}, res_vidx};

  ffvd_ram #(.WIDTH(3*KW), .DEPTH(DEPTH)) u_keys (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[AW-1:0]),
    .wdata (key),
    .raddr (idx),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      count      <= '0;
      idx        <= '0;
      key        <= '0;
      last_q     <= 1'b0;
      res_vidx   <= '0;
      res_new    <= 1'b0;
      res_status <= ffvd_pkg::ST_OK;
      out_valid  <= 1'b0;
      out_vidx   <= '0;
      out_new    <= 1'b0;
      out_key    <= '0;
      out_status <= ffvd_pkg::ST_OK;
      out_last   <= 1'b0;
    end else begin
      if (out_valid && out_ready && state != S_EMIT) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            key      <= cmd_key;
            last_q   <= cmd_last;
            idx      <= '0;
            res_vidx <= '0;
            res_new  <= 1'b0;
            unique case (cmd_op)
              ffvd_pkg::OP_CLEAR: begin
                count <= '0;
              end
              ffvd_pkg::OP_ERROR: begin
                res_status <= ffvd_pkg::ST_NEG;
                state      <= S_EMIT;
              end
              ffvd_pkg::OP_LOOKUP: begin
                res_status <= ffvd_pkg::ST_OK;
                state      <= (count == '0) ? S_MISS : S_RD;
              end
              default: begin
                state <= S_IDLE;
              end
            endcase
          end
        end
        S_RD: begin
          state <= S_CMP;
        end
        S_CMP: begin
          priority if (ram_rdata == key) begin
            res_vidx <= idx;
            state    <= S_EMIT;
          end else if (idx_inc == count) begin
            state <= S_MISS;
          end else begin
            idx   <= idx_inc[AW-1:0];
            state <= S_RD;
          end
        end
        S_MISS: begin
          if (count < CW'(DEPTH)) begin
            res_vidx <= count[AW-1:0];
            res_new  <= 1'b1;
            count    <= count + {{AW{1'b0}}, 1'b1};
          end else begin
            res_status <= ffvd_pkg::ST_FULL;
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || out_ready) begin
            out_valid  <= 1'b1;
            out_vidx   <= vidx_wide[ffvd_pkg::OUT_IDX_BITS-1:0];
            out_new    <= res_new;
            out_key    <= key;
            out_status <= res_status;
            out_last   <= last_q;
            state      <= S_IDLE;
          end
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/face_fan_vertex_dedup.sv @@
// ----------------------------------------------------------------------------
// face_fan_vertex_dedup
// Fan triangulation of polygon corners with vertex index deduplication.
// ----------------------------------------------------------------------------
// Flow: an accepted corner passes through the front part and the command queue
//   to the back part, which reads and compares the table entries in turn; a
//   mesh start first issues a clear command. The back part takes one command
//   at a time; a corner issues one or three lookups or one error command, and
//   a dropped corner issues none.
// Reset: rst clears the entry count and face state; the key RAM is not swept.
module face_fan_vertex_dedup #(
  parameter int TABLE_DEPTH = 1024,
  parameter int INDEX_BITS  = 24
) (
  input  logic clk,
  input  logic rst,
  input  logic s_tvalid,
  output logic s_tready,
  // pos_index, uv_index, normal_index, pos_count, uv_count, normal_count
  input  logic [((6*INDEX_BITS-3)+7)/8*8-1:0] s_tdata,
  // face_start, mesh_start
  input  logic [1:0] s_tuser,
  output logic m_tvalid,
  input  logic m_tready,
  // vertex_index, is_new, res_pos_index, res_uv_index, res_normal_index
  output logic [((ffvd_pkg::OUT_IDX_BITS+1+3*(INDEX_BITS-1))+7)/8*8-1:0] m_tdata,
  // status
  output logic [ffvd_pkg::STATUS_BITS-1:0] m_tuser,
  output logic m_tlast
);

  localparam int IB  = INDEX_BITS;
  localparam int KW  = IB - 1;
  localparam int QW  = 3*KW + 3;
  localparam int OPW = ((ffvd_pkg::OUT_IDX_BITS+1+3*KW)+7)/8*8;

  logic              f_valid;
  logic              f_ready;
  ffvd_pkg::op_t     f_op;
  logic [3*KW-1:0]   f_key;
  logic              f_last;
  logic              q_valid;
  logic              q_ready;
  logic [QW-1:0]     q_data;
  ffvd_pkg::op_t     q_op;
  logic [ffvd_pkg::OUT_IDX_BITS-1:0] o_vidx;
  logic              o_new;
  logic [3*KW-1:0]   o_key;
  ffvd_pkg::status_t o_status;

  ffvd_front #(.IB(IB)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .pos_index    (s_tdata[IB-1:0]),
    .uv_index     (s_tdata[2*IB-1:IB]),
    .normal_index (s_tdata[3*IB-1:2*IB]),
    .pos_count    (s_tdata[3*IB+KW-1:3*IB]),
    .uv_count     (s_tdata[3*IB+2*KW-1:3*IB+KW]),
    .normal_count (s_tdata[3*IB+3*KW-1:3*IB+2*KW]),
    .face_start   (s_tuser[0]),
    .mesh_start   (s_tuser[1]),
    .cmd_valid    (f_valid),
    .cmd_ready    (f_ready),
    .cmd_op       (f_op),
    .cmd_key      (f_key),
    .cmd_last     (f_last)
  );

  ffvd_queue #(.WIDTH(QW)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_data  ({f_last, f_op, f_key}),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_data)
  );

  assign q_op = ffvd_pkg::op_t'(q_data[3*KW+1:3*KW]);

  ffvd_back #(.IB(IB), .DEPTH(TABLE_DEPTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (q_valid),
    .cmd_ready  (q_ready),
    .cmd_op     (q_op),
    .cmd_key    (q_data[3*KW-1:0]),
    .cmd_last   (q_data[QW-1]),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_vidx   (o_vidx),
    .out_new    (o_new),
    .out_key    (o_key),
    .out_status (o_status),
    .out_last   (m_tlast)
  );

  assign m_tdata = OPW'({o_key, o_new, o_vidx});
  assign m_tuser = o_status;

`ifndef NO_ASSERTIONS
  a_neg_is_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status == ffvd_pkg::ST_NEG) |-> (m_tlast && o_key == '0))
    else $error("negative index result not a lone zero result");

  a_new_is_ok: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_new) |-> (o_status == ffvd_pkg::ST_OK))
    else $error("inserted vertex with non-ok status");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && o_status == ffvd_pkg::ST_FULL) |-> (o_vidx == '0 && !o_new))
    else $error("full table result carries an index");
`endif

endmodule
